/* rtl/pcq_pkg.sv */
// shared types, constants and helpers for the quaternion pose composer
package pcq_pkg;

  // quaternion and matrix fraction bits
  localparam int QF = 30;
  // rotation unit: halve, multiply, numerators, QF+1 divide steps, output
  localparam int ROT_LAT = QF + 5;
  // extraction: trace select, root steps, divisor prep, quotient steps
  localparam int SQRT_STEPS = 32;
  localparam int QDIV_STEPS = 32;
  localparam int EXT_LAT = SQRT_STEPS + QDIV_STEPS + 2;

  localparam int NUM_REGS = 7;
  localparam int REG_POS_X = 0;
  localparam int REG_QUAT_W = 3;

  typedef logic signed [31:0] word_t;
  typedef word_t quat_t [4];
  typedef word_t mat_t [9];

  localparam word_t ONE_Q = word_t'(64'sd1 <<< QF);
  // components beyond this magnitude get halved first
  localparam word_t QUAT_BIG = 32'sh4000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t MOUNT_QUAT_W_RST = 32'sh4000_0000;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t res;
    if (v > 64'(WORD_MAX)) begin
      res = WORD_MAX;
    end else if (v < 64'(WORD_MIN)) begin
      res = WORD_MIN;
    end else begin
      res = word_t'(v[31:0]);
    end
    return res;
  endfunction

endpackage

/* rtl/pcq_if.sv */
// request channels for input poses and composed results
interface pcq_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic signed [31:0] in_quat_w;
  logic signed [31:0] in_quat_x;
  logic signed [31:0] in_quat_y;
  logic signed [31:0] in_quat_z;

  modport source (
    output valid, in_pos_x, in_pos_y, in_pos_z,
    output in_quat_w, in_quat_x, in_quat_y, in_quat_z,
    input  ready
  );
  modport sink (
    input  valid, in_pos_x, in_pos_y, in_pos_z,
    input  in_quat_w, in_quat_x, in_quat_y, in_quat_z,
    output ready
  );
endinterface

interface pcq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_quat_w;
  logic signed [31:0] out_quat_x;
  logic signed [31:0] out_quat_y;
  logic signed [31:0] out_quat_z;
  logic               degenerate;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z,
    output out_quat_w, out_quat_x, out_quat_y, out_quat_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z,
    input  out_quat_w, out_quat_x, out_quat_y, out_quat_z, degenerate,
    output ready
  );
endinterface

/* rtl/pcq_rot.sv */
// pipelined quaternion to rotation matrix, normalized by squared norm
module pcq_rot (
  input  logic           clk,
  input  logic           en,
  input  pcq_pkg::quat_t quat,
  output pcq_pkg::mat_t  mat,
  output logic           zero
);
  import pcq_pkg::*;

  localparam int NDIV = QF + 1;

  logic               big;
  word_t              h1_r [4];
  logic               z1_r;
  logic signed [63:0] p2_r [10];
  logic               z2_r;
  logic signed [63:0] num_nxt [9];
  logic [63:0]        a3_r [9];
  logic               neg3_r [9];
  logic [63:0]        d3_r;
  logic               z3_r;
  logic [63:0]        rem_r [NDIV][9];
  logic [NDIV-1:0]    quo_r [NDIV][9];
  logic               neg_r [NDIV][9];
  logic [63:0]        den_r [NDIV];
  logic               zs_r [NDIV];
  mat_t               mat_r;
  logic               zero_r;

  function automatic logic signed [63:0] mul(input word_t a, input word_t b);
    return 64'(a) * 64'(b);
  endfunction

  // oversized components halve the whole quaternion
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (quat[i] > QUAT_BIG || quat[i] < -QUAT_BIG) big = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) h1_r[i] <= big ? (quat[i] >>> 1) : quat[i];
      z1_r <= (quat[0] == '0) && (quat[1] == '0) && (quat[2] == '0) && (quat[3] == '0);
    end
  end

  // squares and cross products: w w, x x, y y, z z, x y, z w, x z, y w, y z, x w
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r[0] <= mul(h1_r[0], h1_r[0]);
      p2_r[1] <= mul(h1_r[1], h1_r[1]);
      p2_r[2] <= mul(h1_r[2], h1_r[2]);
      p2_r[3] <= mul(h1_r[3], h1_r[3]);
      p2_r[4] <= mul(h1_r[1], h1_r[2]);
      p2_r[5] <= mul(h1_r[3], h1_r[0]);
      p2_r[6] <= mul(h1_r[1], h1_r[3]);
      p2_r[7] <= mul(h1_r[2], h1_r[0]);
      p2_r[8] <= mul(h1_r[2], h1_r[3]);
      p2_r[9] <= mul(h1_r[1], h1_r[0]);
      z2_r    <= z1_r;
    end
  end

  // matrix numerators, row major
  always_comb begin
    num_nxt[0] = p2_r[1] - p2_r[2] - p2_r[3] + p2_r[0];
    num_nxt[4] = p2_r[2] - p2_r[1] - p2_r[3] + p2_r[0];
    num_nxt[8] = p2_r[3] - p2_r[1] - p2_r[2] + p2_r[0];
    num_nxt[3] = (p2_r[4] + p2_r[5]) <<< 1;
    num_nxt[1] = (p2_r[4] - p2_r[5]) <<< 1;
    num_nxt[6] = (p2_r[6] - p2_r[7]) <<< 1;
    num_nxt[2] = (p2_r[6] + p2_r[7]) <<< 1;
    num_nxt[7] = (p2_r[8] + p2_r[9]) <<< 1;
    num_nxt[5] = (p2_r[8] - p2_r[9]) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        a3_r[k]   <= num_nxt[k][63] ? 64'(-num_nxt[k]) : 64'(num_nxt[k]);
        neg3_r[k] <= num_nxt[k][63];
      end
      d3_r <= 64'(p2_r[0] + p2_r[1] + p2_r[2] + p2_r[3]);
      z3_r <= z2_r;
    end
  end

  // restoring divide, one quotient bit per stage; numerator never exceeds norm
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [63:0]     src_rem [9];
    logic [NDIV-1:0] src_quo [9];
    logic            src_neg [9];
    logic [63:0]     src_den;
    logic            src_z;

    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          src_rem[k] = a3_r[k];
          src_quo[k] = '0;
          src_neg[k] = neg3_r[k];
        end
        src_den = d3_r;
        src_z   = z3_r;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          src_rem[k] = rem_r[j-1][k] << 1;
          src_quo[k] = quo_r[j-1][k];
          src_neg[k] = neg_r[j-1][k];
        end
        src_den = den_r[j-1];
        src_z   = zs_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 9; k++) begin
          if (src_rem[k] >= src_den) begin
            rem_r[j][k] <= src_rem[k] - src_den;
            quo_r[j][k] <= {src_quo[k][NDIV-2:0], 1'b1};
          end else begin
            rem_r[j][k] <= src_rem[k];
            quo_r[j][k] <= {src_quo[k][NDIV-2:0], 1'b0};
          end
          neg_r[j][k] <= src_neg[k];
        end
        den_r[j] <= src_den;
        zs_r[j]  <= src_z;
      end
    end
  end

  // zero quaternion falls back to identity
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (zs_r[NDIV-1]) begin
          mat_r[k] <= (k % 4 == 0) ? ONE_Q : '0;
        end else if (neg_r[NDIV-1][k]) begin
          mat_r[k] <= -$signed(32'(quo_r[NDIV-1][k]));
        end else begin
          mat_r[k] <= $signed(32'(quo_r[NDIV-1][k]));
        end
      end
      zero_r <= zs_r[NDIV-1];
    end
  end

  assign mat  = mat_r;
  assign zero = zero_r;

endmodule

/* rtl/pcq_ext.sv */
// pipelined rotation matrix to quaternion, four-branch trace method
module pcq_ext (
  input  logic           clk,
  input  logic           en,
  input  pcq_pkg::mat_t  c,
  output pcq_pkg::quat_t q
);
  import pcq_pkg::*;

  typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} br_t;

  logic signed [33:0] tr;
  logic signed [33:0] t;
  br_t                br;
  logic signed [32:0] n_nxt [3];
  logic [63:0]        e_v_r;
  br_t                e_br_r;
  logic signed [32:0] e_n_r [3];

  logic [63:0]        sq_v_r [SQRT_STEPS];
  logic [63:0]        sq_res_r [SQRT_STEPS];
  br_t                sq_br_r [SQRT_STEPS];
  logic signed [32:0] sq_n_r [SQRT_STEPS][3];

  logic [32:0]        s_raw;
  logic [32:0]        s_div;
  logic [31:0]        mag [3];
  logic [32:0]        p_s_r;
  word_t              p_half_r;
  br_t                p_br_r;
  logic [33:0]        p_rem_r [3];
  logic [1:0]         p_lo_r [3];
  logic               p_neg_r [3];
  logic               p_ovf_r [3];

  logic [33:0]        dv_rem_r [QDIV_STEPS][3];
  logic [31:0]        dv_quo_r [QDIV_STEPS][3];
  logic [1:0]         dv_lo_r [QDIV_STEPS][3];
  logic               dv_neg_r [QDIV_STEPS][3];
  logic               dv_ovf_r [QDIV_STEPS][3];
  logic [32:0]        dv_s_r [QDIV_STEPS];
  word_t              dv_half_r [QDIV_STEPS];
  br_t                dv_br_r [QDIV_STEPS];

  word_t              lane [3];

  // branch pick and square-root argument
  always_comb begin
    tr = 34'(c[0]) + 34'(c[4]) + 34'(c[8]);
    priority if (tr > 0) begin
      br = BR_TRACE;
    end else if (c[0] > c[4] && c[0] > c[8]) begin
      br = BR_X;
    end else if (c[4] > c[8]) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end
    unique case (br)
      BR_TRACE: begin
        t = tr + 34'(ONE_Q);
        n_nxt[0] = 33'(c[7]) - 33'(c[5]);
        n_nxt[1] = 33'(c[2]) - 33'(c[6]);
        n_nxt[2] = 33'(c[3]) - 33'(c[1]);
      end
      BR_X: begin
        t = 34'(ONE_Q) + 34'(c[0]) - 34'(c[4]) - 34'(c[8]);
        n_nxt[0] = 33'(c[7]) - 33'(c[5]);
        n_nxt[1] = 33'(c[3]) + 33'(c[1]);
        n_nxt[2] = 33'(c[2]) + 33'(c[6]);
      end
      BR_Y: begin
        t = 34'(ONE_Q) - 34'(c[0]) + 34'(c[4]) - 34'(c[8]);
        n_nxt[0] = 33'(c[2]) - 33'(c[6]);
        n_nxt[1] = 33'(c[3]) + 33'(c[1]);
        n_nxt[2] = 33'(c[7]) + 33'(c[5]);
      end
      BR_Z: begin
        t = 34'(ONE_Q) - 34'(c[0]) - 34'(c[4]) + 34'(c[8]);
        n_nxt[0] = 33'(c[3]) - 33'(c[1]);
        n_nxt[1] = 33'(c[2]) + 33'(c[6]);
        n_nxt[2] = 33'(c[7]) + 33'(c[5]);
      end
      default: begin
        t = '0;
        n_nxt[0] = '0;
        n_nxt[1] = '0;
        n_nxt[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_v_r  <= t[33] ? '0 : (64'($unsigned(t)) << QF);
      e_br_r <= br;
      for (int k = 0; k < 3; k++) e_n_r[k] <= n_nxt[k];
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]        src_v;
    logic [63:0]        src_res;
    br_t                src_br;
    logic signed [32:0] src_n [3];
    logic [63:0]        trial;

    if (k == 0) begin : g_first
      always_comb begin
        src_v   = e_v_r;
        src_res = '0;
        src_br  = e_br_r;
        for (int i = 0; i < 3; i++) src_n[i] = e_n_r[i];
      end
    end else begin : g_next
      always_comb begin
        src_v   = sq_v_r[k-1];
        src_res = sq_res_r[k-1];
        src_br  = sq_br_r[k-1];
        for (int i = 0; i < 3; i++) src_n[i] = sq_n_r[k-1][i];
      end
    end

    assign trial = src_res + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (src_v >= trial) begin
          sq_v_r[k]   <= src_v - trial;
          sq_res_r[k] <= (src_res >> 1) + BIT;
        end else begin
          sq_v_r[k]   <= src_v;
          sq_res_r[k] <= src_res >> 1;
        end
        sq_br_r[k] <= src_br;
        for (int i = 0; i < 3; i++) sq_n_r[k][i] <= src_n[i];
      end
    end
  end

  // divisor s = 2 root, never zero; quotient past 32 bits only saturates
  always_comb begin
    s_raw = 33'(sq_res_r[SQRT_STEPS-1][31:0]) << 1;
    s_div = (s_raw == '0) ? 33'd1 : s_raw;
    for (int i = 0; i < 3; i++) begin
      mag[i] = sq_n_r[SQRT_STEPS-1][i][32] ? 32'(-sq_n_r[SQRT_STEPS-1][i])
                                           : 32'(sq_n_r[SQRT_STEPS-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s_r    <= s_div;
      p_half_r <= word_t'(32'(s_raw >> 2));
      p_br_r   <= sq_br_r[SQRT_STEPS-1];
      for (int i = 0; i < 3; i++) begin
        p_rem_r[i] <= 34'(mag[i] >> 2);
        p_lo_r[i]  <= mag[i][1:0];
        p_neg_r[i] <= sq_n_r[SQRT_STEPS-1][i][32];
        p_ovf_r[i] <= 35'(mag[i]) >= (35'(s_div) << 2);
      end
    end
  end

  // quotient of |n| * 2^QF by s, one bit per stage
  for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_qdiv
    logic [33:0] src_rem [3];
    logic [31:0] src_quo [3];
    logic [1:0]  src_lo [3];
    logic        src_neg [3];
    logic        src_ovf [3];
    logic [32:0] src_s;
    word_t       src_half;
    br_t         src_br;
    logic [33:0] sh [3];

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          src_rem[i] = p_rem_r[i];
          src_quo[i] = '0;
          src_lo[i]  = p_lo_r[i];
          src_neg[i] = p_neg_r[i];
          src_ovf[i] = p_ovf_r[i];
        end
        src_s    = p_s_r;
        src_half = p_half_r;
        src_br   = p_br_r;
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          src_rem[i] = dv_rem_r[k-1][i];
          src_quo[i] = dv_quo_r[k-1][i];
          src_lo[i]  = dv_lo_r[k-1][i];
          src_neg[i] = dv_neg_r[k-1][i];
          src_ovf[i] = dv_ovf_r[k-1][i];
        end
        src_s    = dv_s_r[k-1];
        src_half = dv_half_r[k-1];
        src_br   = dv_br_r[k-1];
      end
    end

    // the two low bits of |n| enter first, zeros after
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          sh[i] = {src_rem[i][32:0], src_lo[i][1]};
        end else if (k == 1) begin
          sh[i] = {src_rem[i][32:0], src_lo[i][0]};
        end else begin
          sh[i] = {src_rem[i][32:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (sh[i] >= 34'(src_s)) begin
            dv_rem_r[k][i] <= sh[i] - 34'(src_s);
            dv_quo_r[k][i] <= {src_quo[i][30:0], 1'b1};
          end else begin
            dv_rem_r[k][i] <= sh[i];
            dv_quo_r[k][i] <= {src_quo[i][30:0], 1'b0};
          end
          dv_lo_r[k][i]  <= src_lo[i];
          dv_neg_r[k][i] <= src_neg[i];
          dv_ovf_r[k][i] <= src_ovf[i];
        end
        dv_s_r[k]    <= src_s;
        dv_half_r[k] <= src_half;
        dv_br_r[k]   <= src_br;
      end
    end
  end

  // sign, saturation and placement of the half term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_ovf_r[QDIV_STEPS-1][i] || dv_quo_r[QDIV_STEPS-1][i][31]) begin
        lane[i] = dv_neg_r[QDIV_STEPS-1][i] ? WORD_MIN : WORD_MAX;
      end else if (dv_neg_r[QDIV_STEPS-1][i]) begin
        lane[i] = -$signed(dv_quo_r[QDIV_STEPS-1][i]);
      end else begin
        lane[i] = $signed(dv_quo_r[QDIV_STEPS-1][i]);
      end
    end
    q[0] = (dv_br_r[QDIV_STEPS-1] == BR_TRACE) ? dv_half_r[QDIV_STEPS-1] : lane[0];
    q[1] = (dv_br_r[QDIV_STEPS-1] == BR_X) ? dv_half_r[QDIV_STEPS-1]
         : (dv_br_r[QDIV_STEPS-1] == BR_TRACE) ? lane[0] : lane[1];
    q[2] = (dv_br_r[QDIV_STEPS-1] == BR_Y) ? dv_half_r[QDIV_STEPS-1]
         : (dv_br_r[QDIV_STEPS-1] == BR_Z) ? lane[2] : lane[1];
    q[3] = (dv_br_r[QDIV_STEPS-1] == BR_Z) ? dv_half_r[QDIV_STEPS-1] : lane[2];
  end

endmodule

/* rtl/pose_compose_quaternion_top.sv */
// quaternion pose composer: mount pose times input pose, fully pipelined
//
//   channel   dir  fields                                    handshake
//   in_pose   in   in_pos_x/y/z, in_quat_w/x/y/z             valid/ready
//   out_pose  out  out_pos_x/y/z, out_quat_w/x/y/z, degen.   valid/ready
//   cfg_*     in   cfg_index selects mount register          cfg_we, no wait
//
// one request per cycle sustained, except while the output buffer is full and
// out_pose.ready is low; the pipe holds the quaternion-to-matrix divide, the matrix
// product, then root and quotient extraction, its depth set by the bit-per-stage divide and root chains
// the whole pipe advances on one enable; a two-entry output buffer keeps
// in_pose.ready high while one finished request waits downstream
// synchronous active-low reset clears valid bits and the buffer count and
// loads the mount pose with identity rotation and zero offset
module pose_compose_quaternion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pcq_in_if.sink      in_pose,
  pcq_out_if.source   out_pose
);
  import pcq_pkg::*;

  localparam int NSTG = ROT_LAT + 2 + EXT_LAT;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               degenerate;
  } res_t;

  // mount pose registers
  word_t              mount_r [NUM_REGS];

  // pipe control
  logic               en;
  logic [NSTG-1:0]    vld_r;

  // quaternion to matrix, mount and input in parallel
  quat_t              mq;
  quat_t              iq;
  mat_t               ma;
  mat_t               mb;
  logic               za;
  logic               zb;
  word_t              ip_r [ROT_LAT][3];

  // matrix product and position transform
  logic signed [63:0] mm_r [27];
  logic signed [63:0] pp_r [9];
  logic               deg1_r;
  mat_t               c2_nxt;
  word_t              pos2_nxt [3];
  mat_t               c2_r;
  word_t              pos2_r [3];
  logic               deg2_r;

  // extraction and side data delay
  quat_t              qx;
  word_t              pd_r [EXT_LAT][3];
  logic               dd_r [EXT_LAT];

  // output buffer
  logic [1:0]         cnt_r;
  res_t               head_r;
  res_t               tail_r;
  res_t               res_new;
  logic               push;
  logic               pop;

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) mount_r[i] <= '0;
      mount_r[REG_QUAT_W] <= MOUNT_QUAT_W_RST;
    end else if (cfg_we && (int'(cfg_index) < NUM_REGS)) begin
      mount_r[cfg_index] <= $signed(cfg_data);
    end
  end

  // global advance: stop only when both buffer slots hold unread results
  assign en            = (cnt_r != 2'd2) || out_pose.ready;
  assign in_pose.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_pose.valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) mq[i] = mount_r[REG_QUAT_W + i];
    iq[0] = in_pose.in_quat_w;
    iq[1] = in_pose.in_quat_x;
    iq[2] = in_pose.in_quat_y;
    iq[3] = in_pose.in_quat_z;
  end

  pcq_rot u_rot_mount (
    .clk  (clk),
    .en   (en),
    .quat (mq),
    .mat  (ma),
    .zero (za)
  );

  pcq_rot u_rot_in (
    .clk  (clk),
    .en   (en),
    .quat (iq),
    .mat  (mb),
    .zero (zb)
  );

  // input position rides alongside the rotation unit
  always_ff @(posedge clk) begin
    if (en) begin
      ip_r[0][0] <= in_pose.in_pos_x;
      ip_r[0][1] <= in_pose.in_pos_y;
      ip_r[0][2] <= in_pose.in_pos_z;
      for (int s = 1; s < ROT_LAT; s++) ip_r[s] <= ip_r[s-1];
    end
  end

  // all 27 matrix products plus mount rotation of the input position
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            mm_r[(i * 3 + j) * 3 + k] <= 64'(ma[i * 3 + k]) * 64'(mb[k * 3 + j]);
          end
          pp_r[i * 3 + j] <= 64'(ma[i * 3 + j]) * 64'(ip_r[ROT_LAT-1][j]);
        end
      end
      deg1_r <= za | zb;
    end
  end

  // sums, rescale, clamp entries to unit range, saturate positions
  always_comb begin
    logic signed [63:0] e;
    logic signed [63:0] acc;
    for (int m = 0; m < 9; m++) begin
      e = (mm_r[m * 3] + mm_r[m * 3 + 1] + mm_r[m * 3 + 2]) >>> QF;
      if (e > 64'(ONE_Q)) begin
        c2_nxt[m] = ONE_Q;
      end else if (e < -64'(ONE_Q)) begin
        c2_nxt[m] = -ONE_Q;
      end else begin
        c2_nxt[m] = word_t'(e[31:0]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = (pp_r[i * 3] + pp_r[i * 3 + 1] + pp_r[i * 3 + 2]) >>> QF;
      pos2_nxt[i] = sat32(acc + 64'(mount_r[REG_POS_X + i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= c2_nxt;
      pos2_r <= pos2_nxt;
      deg2_r <= deg1_r;
    end
  end

  pcq_ext u_ext (
    .clk (clk),
    .en  (en),
    .c   (c2_r),
    .q   (qx)
  );

  // position and flag wait for the quaternion
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= pos2_r;
      dd_r[0] <= deg2_r;
      for (int s = 1; s < EXT_LAT; s++) begin
        pd_r[s] <= pd_r[s-1];
        dd_r[s] <= dd_r[s-1];
      end
    end
  end

  always_comb begin
    res_new.pos_x      = pd_r[EXT_LAT-1][0];
    res_new.pos_y      = pd_r[EXT_LAT-1][1];
    res_new.pos_z      = pd_r[EXT_LAT-1][2];
    res_new.quat_w     = qx[0];
    res_new.quat_x     = qx[1];
    res_new.quat_y     = qx[2];
    res_new.quat_z     = qx[3];
    res_new.degenerate = dd_r[EXT_LAT-1];
  end

  assign push = en && vld_r[NSTG-1];
  assign pop  = (cnt_r != 2'd0) && out_pose.ready;

  // two-entry output buffer, head always drives the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      priority if (push && pop) begin
        if (cnt_r == 2'd1) begin
          head_r <= res_new;
        end else begin
          head_r <= tail_r;
          tail_r <= res_new;
        end
      end else if (push) begin
        if (cnt_r == 2'd0) begin
          head_r <= res_new;
        end else begin
          tail_r <= res_new;
        end
        cnt_r <= cnt_r + 2'd1;
      end else if (pop) begin
        head_r <= tail_r;
        cnt_r  <= cnt_r - 2'd1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

  assign out_pose.valid      = (cnt_r != 2'd0);
  assign out_pose.out_pos_x  = head_r.pos_x;
  assign out_pose.out_pos_y  = head_r.pos_y;
  assign out_pose.out_pos_z  = head_r.pos_z;
  assign out_pose.out_quat_w = head_r.quat_w;
  assign out_pose.out_quat_x = head_r.quat_x;
  assign out_pose.out_quat_y = head_r.quat_y;
  assign out_pose.out_quat_z = head_r.quat_z;
  assign out_pose.degenerate = head_r.degenerate;

  // buffer never holds more than two results
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  // an empty buffer cannot fill both slots in one cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |=> cnt_r != 2'd2)
    else $error("output buffer count jumped");

  // a full buffer with no drain stays full and keeps its head
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_pose.ready) |=> (cnt_r == 2'd2 && $stable(head_r)))
    else $error("full output buffer changed without a drain");

endmodule

/* tb/tb_pose_compose_quaternion_top.sv */
// self-checking bench for the quaternion pose composer: directed rows, then random poses
`timescale 1ns / 100ps

module tb_pose_compose_quaternion_top;
  import pcq_pkg::*;

  // one composed pose as the output channel carries it
  typedef struct {
    word_t pos [3];
    word_t quat [4];
    logic  degen;
  } pose_res_t;

  // one directed row: input fields, and a typed result where one is given
  typedef struct {
    word_t     fld [7];
    bit        typed;
    pose_res_t res;
  } pose_row_t;

  localparam int  HALF_PERIOD = 1;
  localparam int  DRAIN_CYCLES = 110;  // a bit over the pipe latency
  localparam int  STALL_LIMIT = 20000;
  localparam int  RAND_PER_PHASE = 360;
  localparam int  NUM_PHASES = 5;
  localparam int  REG_NONE = 7;        // index past the last mount register
  localparam longint ONE_L = 64'sd1 <<< QF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pcq_in_if  in_pose_if ();
  pcq_out_if out_pose_if ();

  pose_compose_quaternion_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pose   (in_pose_if),
    .out_pose  (out_pose_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // bench copy of the mount registers
  word_t     mount_regs [NUM_REGS];
  pose_res_t pending_poses [$];
  int        err_count = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // num * 2^QF / den, truncated toward zero
  function automatic longint ratio_of(input longint num, input longint den);
    logic [127:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << QF) / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_word(input longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  // quaternion to row-major rotation matrix, normalized by the squared norm
  function automatic bit rot_of(input word_t qi [4], output longint m [9]);
    longint c [4];
    longint n, w, x, y, z;
    bit big;
    big = 0;
    for (int i = 0; i < 4; i++) begin
      c[i] = qi[i];
      if (c[i] > ONE_L || c[i] < -ONE_L) big = 1;
    end
    // oversized quaternion: halve all parts, the rotation keeps
    if (big) for (int i = 0; i < 4; i++) c[i] = c[i] >>> 1;
    w = c[0]; x = c[1]; y = c[2]; z = c[3];
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? ONE_L : 0;
      return 1;
    end
    n = w*w + x*x + y*y + z*z;
    m[0] = ratio_of(x*x - y*y - z*z + w*w, n);
    m[4] = ratio_of(-x*x + y*y - z*z + w*w, n);
    m[8] = ratio_of(-x*x - y*y + z*z + w*w, n);
    m[3] = ratio_of(2 * (x*y + z*w), n);
    m[1] = ratio_of(2 * (x*y - z*w), n);
    m[6] = ratio_of(2 * (x*z - y*w), n);
    m[2] = ratio_of(2 * (x*z + y*w), n);
    m[7] = ratio_of(2 * (y*z + x*w), n);
    m[5] = ratio_of(2 * (y*z - x*w), n);
    return 0;
  endfunction

  function automatic pose_res_t compose_pose(input word_t fld [7]);
    pose_res_t r;
    word_t  mq [4], iq [4];
    longint a [9], b [9], cm [9], q [4];
    longint e, acc, tr, t, s, half;
    bit deg;
    for (int i = 0; i < 4; i++) begin
      mq[i] = mount_regs[REG_QUAT_W + i];
      iq[i] = fld[3 + i];
    end
    deg = rot_of(mq, a);
    deg |= rot_of(iq, b);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        e = 0;
        for (int k = 0; k < 3; k++) e += a[i*3+k] * b[k*3+j];
        e = e >>> QF;
        // composed entries clamp to +-1.0 before extraction
        cm[i*3+j] = (e > ONE_L) ? ONE_L : (e < -ONE_L) ? -ONE_L : e;
        acc += a[i*3+j] * longint'(fld[j]);
      end
      r.pos[i] = word_t'(sat_word((acc >>> QF) + longint'(mount_regs[REG_POS_X + i])));
    end
    // four-branch trace extraction
    tr = cm[0] + cm[4] + cm[8];
    if (tr > 0) t = tr + ONE_L;
    else if (cm[0] > cm[4] && cm[0] > cm[8]) t = ONE_L + cm[0] - cm[4] - cm[8];
    else if (cm[4] > cm[8]) t = ONE_L - cm[0] + cm[4] - cm[8];
    else t = ONE_L - cm[0] - cm[4] + cm[8];
    if (t < 0) t = 0;
    s = 2 * longint'(int_root(longint'(t) * ONE_L));
    half = s >>> 2;
    if (s == 0) s = 1;
    if (tr > 0) begin
      q[0] = half;
      q[1] = (cm[7] - cm[5]) * ONE_L / s;
      q[2] = (cm[2] - cm[6]) * ONE_L / s;
      q[3] = (cm[3] - cm[1]) * ONE_L / s;
    end else if (cm[0] > cm[4] && cm[0] > cm[8]) begin
      q[0] = (cm[7] - cm[5]) * ONE_L / s;
      q[1] = half;
      q[2] = (cm[3] + cm[1]) * ONE_L / s;
      q[3] = (cm[2] + cm[6]) * ONE_L / s;
    end else if (cm[4] > cm[8]) begin
      q[0] = (cm[2] - cm[6]) * ONE_L / s;
      q[1] = (cm[3] + cm[1]) * ONE_L / s;
      q[2] = half;
      q[3] = (cm[7] + cm[5]) * ONE_L / s;
    end else begin
      q[0] = (cm[3] - cm[1]) * ONE_L / s;
      q[1] = (cm[2] + cm[6]) * ONE_L / s;
      q[2] = (cm[7] + cm[5]) * ONE_L / s;
      q[3] = half;
    end
    for (int i = 0; i < 4; i++) r.quat[i] = word_t'(sat_word(q[i]));
    r.degen = deg;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // write enable stays up across a burst; the caller drops it afterwards
  task automatic write_mount(input int idx, input word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data  <= val;
    @(posedge clk);
    if (idx < NUM_REGS) mount_regs[idx] = val;
  endtask

  // present one request, hold it until taken, queue its expected result
  task automatic send_pose(input word_t fld [7], input bit typed, input pose_res_t res);
    // random sender gaps before the request
    while ($urandom_range(99) < send_idle_pct) begin
      in_pose_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_pose_if.valid     <= 1'b1;
    in_pose_if.in_pos_x  <= fld[0];
    in_pose_if.in_pos_y  <= fld[1];
    in_pose_if.in_pos_z  <= fld[2];
    in_pose_if.in_quat_w <= fld[3];
    in_pose_if.in_quat_x <= fld[4];
    in_pose_if.in_quat_y <= fld[5];
    in_pose_if.in_quat_z <= fld[6];
    @(posedge clk);
    while (!in_pose_if.ready) @(posedge clk);
    pending_poses.push_back(typed ? res : compose_pose(fld));
  endtask

  // idle the input side and let the pipe empty out
  task automatic drain_pipe();
    in_pose_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // quaternion part: mostly within +-1.0, some full range, some edge values
  function automatic word_t rand_quat_part(input int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
      2: return word_t'($signed($urandom_range(4095)) - 2048);
      default: return ($urandom_range(1)) ? WORD_MIN : WORD_MAX;
    endcase
  endfunction

  function automatic void rand_pose(output word_t fld [7]);
    int pk, qk;
    pk = $urandom_range(9);
    qk = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (pk == 0) fld[i] = ($urandom_range(1)) ? WORD_MIN : WORD_MAX;
      else if (pk < 4) fld[i] = word_t'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      else fld[i] = rand_word();
    end
    for (int i = 0; i < 4; i++) begin
      if (qk < 3) fld[3 + i] = '0;                      // zero quaternion
      else if (qk < 30) fld[3 + i] = rand_quat_part(0);
      else if (qk < 85) fld[3 + i] = rand_quat_part(1);
      else if (qk < 95) fld[3 + i] = rand_quat_part(2);
      else fld[3 + i] = rand_quat_part($urandom_range(3));
    end
  endfunction

  // ---------------------------------------------------------------------
  // output check and stall pattern
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    out_pose_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pose_res_t want;
    word_t got [7];
    if (rst_n && out_pose_if.valid && out_pose_if.ready) begin
      got = '{out_pose_if.out_pos_x, out_pose_if.out_pos_y, out_pose_if.out_pos_z,
              out_pose_if.out_quat_w, out_pose_if.out_quat_x, out_pose_if.out_quat_y,
              out_pose_if.out_quat_z};
      if (pending_poses.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result request at %0t", $realtime);
      end else begin
        want = pending_poses.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== (i < 3 ? want.pos[i] : want.quat[i - 3])) begin
            err_count++;
            if (err_count <= 10)
              $display("field %0d mismatch: expected %0d got %0d", i,
                       (i < 3 ? want.pos[i] : want.quat[i - 3]), got[i]);
          end
        end
        if (out_pose_if.degenerate !== want.degen) begin
          err_count++;
          if (err_count <= 10)
            $display("degenerate mismatch: expected %0b got %0b", want.degen,
                     out_pose_if.degenerate);
        end
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_pose_if.valid && in_pose_if.ready) || (out_pose_if.valid && out_pose_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pose_compose_quaternion_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  initial begin
    pose_row_t rows [$];
    pose_row_t row;
    pose_res_t ident, none;
    word_t     fld [7];
    word_t     id_q [4];

    in_pose_if.valid     = 1'b0;
    in_pose_if.in_pos_x  = '0;
    in_pose_if.in_pos_y  = '0;
    in_pose_if.in_pos_z  = '0;
    in_pose_if.in_quat_w = '0;
    in_pose_if.in_quat_x = '0;
    in_pose_if.in_quat_y = '0;
    in_pose_if.in_quat_z = '0;
    out_pose_if.ready    = 1'b0;

    for (int i = 0; i < NUM_REGS; i++) mount_regs[i] = '0;
    mount_regs[REG_QUAT_W] = MOUNT_QUAT_W_RST;

    // identity pose out, degenerate flag set or not
    ident.pos  = '{0, 0, 0};
    ident.quat = '{ONE_Q, 0, 0, 0};
    ident.degen = 1'b0;
    none = ident;
    id_q = '{ONE_Q, 0, 0, 0};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, reset mount pose (identity)
    row.typed = 1; row.res = ident;
    row.fld = '{0, 0, 0, ONE_Q, 0, 0, 0};                    rows.push_back(row);
    row.res.degen = 1'b1;
    row.fld = '{0, 0, 0, 0, 0, 0, 0};                        rows.push_back(row);
    // position extremes pass straight through an identity rotation
    row.res = ident;
    row.res.pos = '{WORD_MAX, WORD_MIN, WORD_MAX};
    row.fld = '{WORD_MAX, WORD_MIN, WORD_MAX, ONE_Q, 0, 0, 0}; rows.push_back(row);
    row.res.pos = '{WORD_MIN, WORD_MAX, -1};
    row.fld = '{WORD_MIN, WORD_MAX, -1, ONE_Q, 0, 0, 0};       rows.push_back(row);
    // zero quaternion with extreme position flags degenerate and leaves the position as it is
    row.res.degen = 1'b1;
    row.res.pos = '{WORD_MAX, WORD_MAX, WORD_MIN};
    row.fld = '{WORD_MAX, WORD_MAX, WORD_MIN, 0, 0, 0, 0};     rows.push_back(row);
    // the rest through the predictor
    row.typed = 0; row.res = none;
    row.fld = '{0, 0, 0, WORD_MIN, 0, 0, 0};                 rows.push_back(row);
    row.fld = '{1, 2, 3, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}; rows.push_back(row);
    row.fld = '{1, 2, 3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}; rows.push_back(row);
    row.fld = '{-1, -1, -1, -1, -1, -1, -1};                 rows.push_back(row);
    row.fld = '{1, 1, 1, 1, 0, 0, 0};                        rows.push_back(row);
    // half-turns about x, y and z select the three non-trace branches
    row.fld = '{32'sh10000, 32'sh20000, 32'sh30000, 0, ONE_Q, 0, 0}; rows.push_back(row);
    row.fld = '{32'sh10000, 32'sh20000, 32'sh30000, 0, 0, ONE_Q, 0}; rows.push_back(row);
    row.fld = '{32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0, ONE_Q}; rows.push_back(row);
    row.fld = '{WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, WORD_MIN};   rows.push_back(row);
    row.fld = '{WORD_MIN, WORD_MIN, WORD_MIN, 32'sh2d41_3ccd, 0, 0, 32'sh2d41_3ccd};
    rows.push_back(row);
    row.fld = '{5, -5, 7, 32'sh4000_0001, 0, 32'sh4000_0001, 0};    rows.push_back(row);
    row.fld = '{0, 0, 0, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000};
    rows.push_back(row);
    row.fld = '{0, 0, 0, 0, 32'sh2000_0000, -32'sh2000_0000, 32'sh1000_0000};
    rows.push_back(row);

    foreach (rows[i]) send_pose(rows[i].fld, rows[i].typed, rows[i].res);
    drain_pipe();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // new mount pose while the pipe is empty
      case (ph)
        0: begin
          for (int i = 0; i < NUM_REGS; i++) write_mount(i, rand_word());
        end
        1: begin
          for (int i = 0; i < 3; i++) write_mount(REG_POS_X + i, WORD_MAX);
          for (int i = 0; i < 4; i++) write_mount(REG_QUAT_W + i, WORD_MIN);
          write_mount(REG_NONE, rand_word());
        end
        2: begin
          // zero mount quaternion: every result is degenerate
          for (int i = 0; i < 3; i++) write_mount(REG_POS_X + i, WORD_MIN);
          for (int i = 0; i < 4; i++) write_mount(REG_QUAT_W + i, '0);
        end
        3: begin
          for (int i = 0; i < 3; i++) write_mount(REG_POS_X + i, rand_word());
          for (int i = 0; i < 4; i++) write_mount(REG_QUAT_W + i, rand_quat_part(1));
        end
        default: begin
          for (int i = 0; i < 3; i++) write_mount(REG_POS_X + i, '0);
          for (int i = 0; i < 4; i++) write_mount(REG_QUAT_W + i, id_q[i]);
          write_mount(REG_QUAT_W + 3, WORD_MAX);
        end
      endcase
      cfg_we <= 1'b0;
      // idle pattern per phase: none, sender, receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        rand_pose(fld);
        send_pose(fld, 0, none);
      end
      drain_pipe();
    end

    if (pending_poses.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("tb_pose_compose_quaternion_top: clean");
    end else begin
      $display("tb_pose_compose_quaternion_top: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcq_pkg.sv
rtl/pcq_if.sv
rtl/pcq_rot.sv
rtl/pcq_ext.sv
rtl/pose_compose_quaternion_top.sv
tb/tb_pose_compose_quaternion_top.sv
